// File: rtl/core/grp_pkg.sv
// ----------------------------------------------------------------------------
// grp_pkg
// shared types, codes and sizes of the graphics register port
// ----------------------------------------------------------------------------
package grp_pkg;

   localparam int SPRITE_BYTES    = 256;
   localparam int NAMETABLE_BYTES = 4096;
   localparam int PALETTE_BYTES   = 32;

   localparam int SPR_AW = $clog2(SPRITE_BYTES);
   localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
   localparam int PAL_AW = $clog2(PALETTE_BYTES);
   localparam int MEM_AW = 12;

   // operations
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FLAGS = 2'd2;
   localparam logic [1:0] OP_RESET = 2'd3;

   // register indexes
   localparam logic [2:0] REG_CTRL   = 3'd0;
   localparam logic [2:0] REG_MASK   = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_SADDR  = 3'd3;
   localparam logic [2:0] REG_SDATA  = 3'd4;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   // mirroring modes
   localparam logic [2:0] MIR_HORZ = 3'd1;
   localparam logic [2:0] MIR_LOW  = 3'd2;
   localparam logic [2:0] MIR_HIGH = 3'd3;
   localparam logic [2:0] MIR_FOUR = 3'd4;

   // how the back end updates the bus latch and buffer
   localparam logic [2:0] RK_KEEP   = 3'd0;
   localparam logic [2:0] RK_STATUS = 3'd1;
   localparam logic [2:0] RK_WRITE  = 3'd2;
   localparam logic [2:0] RK_SPR    = 3'd3;
   localparam logic [2:0] RK_BUF    = 3'd4;
   localparam logic [2:0] RK_PAL    = 3'd5;
   localparam logic [2:0] RK_CLEAR  = 3'd6;

   // memory selected by a command
   localparam logic [1:0] MEM_NONE = 2'd0;
   localparam logic [1:0] MEM_SPR  = 2'd1;
   localparam logic [1:0] MEM_NT   = 2'd2;
   localparam logic [1:0] MEM_PAL  = 2'd3;

   typedef struct packed {
      logic [2:0]        rkind;
      logic [1:0]        mkind;
      logic              mwrite;
      logic [MEM_AW-1:0] maddr;
      logic [7:0]        data;
      logic [2:0]        flags;
      logic [7:0]        ext;
      logic              buf_ext;
      logic              gray;
      logic              pattern_write;
      logic [12:0]       pattern_address;
      logic [13:0]       vram;
   } cmd_type;

endpackage

// File: rtl/core/grp_front.sv
// ----------------------------------------------------------------------------
// grp_front
// register file and address logic; turns each bus word into a back-end command
// ----------------------------------------------------------------------------
module grp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [2:0]        csr_data,
   input  logic              accept,
   input  logic [1:0]        operation,
   input  logic [2:0]        register_index,
   input  logic [7:0]        write_data,
   input  logic [7:0]        pattern_read_data,
   output grp_pkg::cmd_type  cmd
);

   logic [2:0]  mode_ff, mode_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic [2:0]  flags_ff, flags_in;
   logic [7:0]  sidx_ff, sidx_in;
   logic        toggle_ff, toggle_in;
   logic [14:0] v_ff, v_in;
   logic [14:0] t_ff, t_in;
   logic [2:0]  fx_ff, fx_in;

   logic [13:0] a;
   logic [13:0] a_inc;
   logic [14:0] v_adv;
   logic [11:0] nt_full;
   logic [4:0]  pal_idx;
   logic [14:0] t_addr2;

   // current address and its step
   assign a     = v_ff[13:0];
   assign a_inc = a + (ctrl_ff[2] ? 14'd32 : 14'd1);
   assign v_adv = {v_ff[14], a_inc};
   assign t_addr2 = {t_ff[14:8], write_data};

   // nametable mirroring
   always_comb begin
      case (mode_ff)
         grp_pkg::MIR_HORZ: nt_full = {1'b0, a[11], a[9:0]};
         grp_pkg::MIR_LOW:  nt_full = {2'b00, a[9:0]};
         grp_pkg::MIR_HIGH: nt_full = {2'b01, a[9:0]};
         grp_pkg::MIR_FOUR: nt_full = a[11:0];
         default:           nt_full = {1'b0, a[10:0]};
      endcase
   end

   // palette entry mirroring of backdrop slots
   assign pal_idx = (a[4] && a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a[4:0];

   // command and next register values
   always_comb begin
      mode_in   = mode_ff;
      ctrl_in   = ctrl_ff;
      mask_in   = mask_ff;
      flags_in  = flags_ff;
      sidx_in   = sidx_ff;
      toggle_in = toggle_ff;
      v_in      = v_ff;
      t_in      = t_ff;
      fx_in     = fx_ff;
      cmd = '0;
      cmd.data  = write_data;
      cmd.ext   = pattern_read_data;
      cmd.flags = flags_ff;
      cmd.gray  = mask_ff[0];
      if (csr_valid) begin
         mode_in = csr_data;
      end
      case (operation)
         grp_pkg::OP_READ: begin
            case (register_index)
               grp_pkg::REG_STATUS: begin
                  cmd.rkind = grp_pkg::RK_STATUS;
                  flags_in  = {1'b0, flags_ff[1:0]};
                  toggle_in = 1'b0;
               end
               grp_pkg::REG_SDATA: begin
                  cmd.rkind = grp_pkg::RK_SPR;
                  cmd.mkind = grp_pkg::MEM_SPR;
                  cmd.maddr = grp_pkg::MEM_AW'(sidx_ff);
               end
               grp_pkg::REG_DATA: begin
                  if (a < 14'h2000) begin
                     cmd.rkind   = grp_pkg::RK_BUF;
                     cmd.buf_ext = 1'b1;
                  end else if (a <= 14'h3EFF) begin
                     cmd.rkind = grp_pkg::RK_BUF;
                     cmd.mkind = grp_pkg::MEM_NT;
                     cmd.maddr = grp_pkg::MEM_AW'(nt_full[grp_pkg::NT_AW-1:0]);
                  end else begin
                     cmd.rkind = grp_pkg::RK_PAL;
                     cmd.mkind = grp_pkg::MEM_PAL;
                     cmd.maddr = grp_pkg::MEM_AW'(pal_idx);
                  end
                  v_in = v_adv;
               end
               default: cmd.rkind = grp_pkg::RK_KEEP;
            endcase
         end
         grp_pkg::OP_WRITE: begin
            cmd.rkind = grp_pkg::RK_WRITE;
            case (register_index)
               grp_pkg::REG_CTRL: begin
                  ctrl_in = write_data;
                  t_in    = {t_ff[14:12], write_data[1:0], t_ff[9:0]};
               end
               grp_pkg::REG_MASK:  mask_in = write_data;
               grp_pkg::REG_SADDR: sidx_in = write_data;
               grp_pkg::REG_SDATA: begin
                  cmd.mkind  = grp_pkg::MEM_SPR;
                  cmd.mwrite = 1'b1;
                  cmd.maddr  = grp_pkg::MEM_AW'(sidx_ff);
                  sidx_in    = sidx_ff + 8'd1;
               end
               grp_pkg::REG_SCROLL: begin
                  if (!toggle_ff) begin
                     fx_in = write_data[2:0];
                     t_in  = {t_ff[14:5], write_data[7:3]};
                  end else begin
                     t_in = {write_data[2:0], t_ff[11:10], write_data[7:3], t_ff[4:0]};
                  end
                  toggle_in = !toggle_ff;
               end
               grp_pkg::REG_ADDR: begin
                  if (!toggle_ff) begin
                     t_in = {1'b0, write_data[5:0], t_ff[7:0]};
                  end else begin
                     t_in = t_addr2;
                     v_in = t_addr2;
                  end
                  toggle_in = !toggle_ff;
               end
               grp_pkg::REG_DATA: begin
                  if (a < 14'h2000) begin
                     cmd.pattern_write   = 1'b1;
                     cmd.pattern_address = a[12:0];
                  end else if (a <= 14'h3EFF) begin
                     cmd.mkind  = grp_pkg::MEM_NT;
                     cmd.mwrite = 1'b1;
                     cmd.maddr  = grp_pkg::MEM_AW'(nt_full[grp_pkg::NT_AW-1:0]);
                  end else begin
                     cmd.mkind  = grp_pkg::MEM_PAL;
                     cmd.mwrite = 1'b1;
                     cmd.maddr  = grp_pkg::MEM_AW'(pal_idx);
                  end
                  v_in = v_adv;
               end
               default: cmd.mkind = grp_pkg::MEM_NONE;
            endcase
         end
         grp_pkg::OP_FLAGS: flags_in = write_data[7:5];
         default: begin
            cmd.rkind = grp_pkg::RK_CLEAR;
            ctrl_in   = '0;
            mask_in   = '0;
            toggle_in = 1'b0;
            v_in      = '0;
            t_in      = '0;
            fx_in     = '0;
         end
      endcase
      // address reported with the word is the one after its step
      cmd.vram = v_in[13:0];
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         ctrl_ff   <= '0;
         mask_ff   <= '0;
         flags_ff  <= '0;
         sidx_ff   <= '0;
         toggle_ff <= 1'b0;
         v_ff      <= '0;
         t_ff      <= '0;
         fx_ff     <= '0;
      end else begin
         mode_ff <= mode_in;
         if (accept) begin
            ctrl_ff   <= ctrl_in;
            mask_ff   <= mask_in;
            flags_ff  <= flags_in;
            sidx_ff   <= sidx_in;
            toggle_ff <= toggle_in;
            v_ff      <= v_in;
            t_ff      <= t_in;
            fx_ff     <= fx_in;
         end
      end
   end

endmodule

// File: rtl/core/grp_queue.sv
// ----------------------------------------------------------------------------
// grp_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module grp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  grp_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output grp_pkg::cmd_type pop_cmd
);

   grp_pkg::cmd_type entry_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_cmd   = entry_ff[rd_ff];

   // pointers and fill level
   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/grp_back.sv
// ----------------------------------------------------------------------------
// grp_back
// sprite, nametable and palette memories, bus latch, read buffer, result word
// ----------------------------------------------------------------------------
module grp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  grp_pkg::cmd_type q_cmd,
   output logic             pop,
   output logic             clearing,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_pattern_write,
   output logic [12:0]      rsp_pattern_address,
   output logic [7:0]       rsp_pattern_write_data,
   output logic [13:0]      rsp_vram_address
);

   localparam int CLR_W = grp_pkg::NT_AW + 1;

   logic [7:0] spr_mem [grp_pkg::SPRITE_BYTES];
   logic [7:0] nt_mem  [grp_pkg::NAMETABLE_BYTES];
   logic [7:0] pal_mem [grp_pkg::PALETTE_BYTES];

   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [7:0]       spr_rd_ff, nt_rd_ff, pal_rd_ff;
   logic             m_valid_ff, m_valid_in;
   grp_pkg::cmd_type m_cmd_ff;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       ob_ff, ob_in;
   logic [7:0]       rb_ff, rb_in;
   logic             adv;
   logic             wr_spr, wr_nt, wr_pal;
   logic [7:0]       pal_val;
   logic [grp_pkg::NT_AW-1:0] clr_addr;

   assign clearing = !clr_ff[CLR_W-1];
   assign clr_addr = clr_ff[grp_pkg::NT_AW-1:0];
   assign clr_in   = clearing ? clr_ff + CLR_W'(1) : clr_ff;
   assign adv      = !out_valid_ff || rsp_ready;
   assign pop      = q_valid && !clearing && (adv || !m_valid_ff);

   assign wr_spr = pop && q_cmd.mwrite && q_cmd.mkind == grp_pkg::MEM_SPR;
   assign wr_nt  = pop && q_cmd.mwrite && q_cmd.mkind == grp_pkg::MEM_NT;
   assign wr_pal = pop && q_cmd.mwrite && q_cmd.mkind == grp_pkg::MEM_PAL;

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // sprite memory
   always_ff @(posedge clock) begin
      if (clearing) begin
         spr_mem[clr_addr[grp_pkg::SPR_AW-1:0]] <= 8'd0;
      end else if (wr_spr) begin
         spr_mem[q_cmd.maddr[grp_pkg::SPR_AW-1:0]] <= q_cmd.data;
      end
      if (pop) begin
         spr_rd_ff <= spr_mem[q_cmd.maddr[grp_pkg::SPR_AW-1:0]];
      end
   end

   // nametable memory
   always_ff @(posedge clock) begin
      if (clearing) begin
         nt_mem[clr_addr] <= 8'd0;
      end else if (wr_nt) begin
         nt_mem[q_cmd.maddr[grp_pkg::NT_AW-1:0]] <= q_cmd.data;
      end
      if (pop) begin
         nt_rd_ff <= nt_mem[q_cmd.maddr[grp_pkg::NT_AW-1:0]];
      end
   end

   // palette memory
   always_ff @(posedge clock) begin
      if (clearing) begin
         pal_mem[clr_addr[grp_pkg::PAL_AW-1:0]] <= 8'd0;
      end else if (wr_pal) begin
         pal_mem[q_cmd.maddr[grp_pkg::PAL_AW-1:0]] <= q_cmd.data;
      end
      if (pop) begin
         pal_rd_ff <= pal_mem[q_cmd.maddr[grp_pkg::PAL_AW-1:0]];
      end
   end

   // memory stage
   assign m_valid_in = (adv || !m_valid_ff) ? pop : m_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         m_cmd_ff <= q_cmd;
      end
   end

   // bus latch and read buffer
   assign pal_val = pal_rd_ff & (m_cmd_ff.gray ? 8'h30 : 8'h3F);

   always_comb begin
      ob_in = ob_ff;
      rb_in = rb_ff;
      case (m_cmd_ff.rkind)
         grp_pkg::RK_STATUS: ob_in = {m_cmd_ff.flags, ob_ff[4:0]};
         grp_pkg::RK_WRITE:  ob_in = m_cmd_ff.data;
         grp_pkg::RK_SPR:    ob_in = spr_rd_ff;
         grp_pkg::RK_BUF: begin
            ob_in = rb_ff;
            rb_in = m_cmd_ff.buf_ext ? m_cmd_ff.ext : nt_rd_ff;
         end
         grp_pkg::RK_PAL: begin
            ob_in = pal_val;
            rb_in = pal_val;
         end
         grp_pkg::RK_CLEAR: begin
            ob_in = 8'd0;
            rb_in = 8'd0;
         end
         default: ob_in = ob_ff;
      endcase
   end

   assign out_valid_in = adv ? m_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         ob_ff        <= 8'd0;
         rb_ff        <= 8'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (adv && m_valid_ff) begin
            ob_ff <= ob_in;
            rb_ff <= rb_in;
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (adv && m_valid_ff) begin
         rsp_pattern_write      <= m_cmd_ff.pattern_write;
         rsp_pattern_address    <= m_cmd_ff.pattern_address;
         rsp_pattern_write_data <= m_cmd_ff.pattern_write ? m_cmd_ff.data : 8'd0;
         rsp_vram_address       <= m_cmd_ff.vram;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = ob_ff;

endmodule

// File: rtl/core/graphics_register_port.sv
// path: a word accepted on the bus passes the queue write, the memory read and
// the result register before its result word is shown
// throughput: one word per cycle while rsp_ready is high and no clearing runs
// reset: synchronous; after reset a clearing pass zeroes the nametable memory
// (and the sprite and palette memories with it) while req_ready is held low
// ----------------------------------------------------------------------------
// graphics_register_port
// cpu-facing register port of a tile graphics unit
// ----------------------------------------------------------------------------
module graphics_register_port (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_register_index,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_pattern_read_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_pattern_write,
   output logic [12:0] rsp_pattern_address,
   output logic [7:0]  rsp_pattern_write_data,
   output logic [13:0] rsp_vram_address
);

   grp_pkg::cmd_type front_cmd, q_cmd;
   logic accept, q_full, q_valid, pop, clearing;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full && !clearing;
   assign accept    = req_valid && req_ready;

   // front: registers and address logic
   grp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .accept            (accept),
      .operation         (req_operation),
      .register_index    (req_register_index),
      .write_data        (req_write_data),
      .pattern_read_data (req_pattern_read_data),
      .cmd               (front_cmd)
   );

   // command queue
   grp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .pop_cmd   (q_cmd)
   );

   // back: memories and result
   grp_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (q_valid),
      .q_cmd                  (q_cmd),
      .pop                    (pop),
      .clearing               (clearing),
      .rsp_ready              (rsp_ready),
      .rsp_valid              (rsp_valid),
      .rsp_read_data          (rsp_read_data),
      .rsp_pattern_write      (rsp_pattern_write),
      .rsp_pattern_address    (rsp_pattern_address),
      .rsp_pattern_write_data (rsp_pattern_write_data),
      .rsp_vram_address       (rsp_vram_address)
   );

endmodule

// File: bench/tb_graphics_register_port.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graphics_register_port
// drives register reads, writes, flag loads and soft resets into the port,
// predicts every response word from a model of the register file and its
// memories, and compares field by field under random idling on both sides
// ----------------------------------------------------------------------------
module tb_graphics_register_port;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] idx;
      logic [7:0] wdata;
      logic [7:0] ext;
   } bus_word_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        pwrite;
      logic [12:0] paddr;
      logic [7:0]  pdata;
      logic [13:0] vram;
   } rsp_word_type;

   typedef struct packed {
      bus_word_type req;
      logic         check;
      rsp_word_type rsp;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [2:0]  req_register_index = '0;
   logic [7:0]  req_write_data = '0;
   logic [7:0]  req_pattern_read_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_pattern_write;
   logic [12:0] rsp_pattern_address;
   logic [7:0]  rsp_pattern_write_data;
   logic [13:0] rsp_vram_address;

   graphics_register_port dut (.*);

   always #1 clock = ~clock;

   // shadow of the register file and memories
   logic [2:0]  m_mirror;
   logic [7:0]  m_ctrl, m_mask, m_spr_idx, m_bus, m_buf;
   logic [2:0]  m_flags, m_fine_x;
   logic        m_toggle;
   logic [14:0] m_v, m_t;
   logic [7:0]  m_spr [grp_pkg::SPRITE_BYTES];
   logic [7:0]  m_nt  [grp_pkg::NAMETABLE_BYTES];
   logic [7:0]  m_pal [grp_pkg::PALETTE_BYTES];

   rsp_word_type pending_rsp [$];
   int           errors = 0;
   int           send_idle = 36, recv_idle = 63;
   bit           recv_hold = 0;
   longint       cycles = 0;

   function automatic int nt_slot(logic [13:0] a);
      int i;
      case (m_mirror)
         grp_pkg::MIR_HORZ: i = ((a >> 1) & 14'h400) + (a & 14'h3FF);
         grp_pkg::MIR_LOW:  i = a & 14'h3FF;
         grp_pkg::MIR_HIGH: i = 14'h400 + (a & 14'h3FF);
         grp_pkg::MIR_FOUR: i = a & 14'hFFF;
         default:           i = a & 14'h7FF;
      endcase
      return i & (grp_pkg::NAMETABLE_BYTES - 1);
   endfunction

   function automatic int pal_slot(logic [13:0] a);
      if ((a & 14'h13) == 14'h10) a = a & ~14'h10;
      return a & 5'h1F;
   endfunction

   function automatic logic [7:0] vram_fetch(logic [13:0] a, logic [7:0] ext);
      if (a < 14'h2000) return ext;
      if (a <= 14'h3EFF) return m_nt[nt_slot(a)];
      return m_pal[pal_slot(a)] & (m_mask[0] ? 8'h30 : 8'h3F);
   endfunction

   function automatic void step_address();
      logic [13:0] s;
      s = m_v[13:0] + (m_ctrl[2] ? 14'd32 : 14'd1);
      m_v = {m_v[14], s};
   endfunction

   function automatic void clear_shadow();
      m_mirror = 0; m_ctrl = 0; m_mask = 0; m_flags = 0; m_spr_idx = 0;
      m_toggle = 0; m_v = 0; m_t = 0; m_fine_x = 0; m_bus = 0; m_buf = 0;
      foreach (m_spr[i]) m_spr[i] = 0;
      foreach (m_nt[i]) m_nt[i] = 0;
      foreach (m_pal[i]) m_pal[i] = 0;
   endfunction

   // predicted response word for one bus word
   function automatic rsp_word_type bus_access(bus_word_type w);
      rsp_word_type r;
      logic [13:0] a;
      r = '0;
      a = m_v[13:0];
      case (w.op)
         grp_pkg::OP_READ: begin
            if (w.idx == grp_pkg::REG_STATUS) begin
               m_bus = (m_bus & 8'h1F) | {m_flags, 5'b0};
               m_flags[2] = 0;
               m_toggle = 0;
            end else if (w.idx == grp_pkg::REG_SDATA) begin
               m_bus = m_spr[m_spr_idx];
            end else if (w.idx == grp_pkg::REG_DATA) begin
               if (a <= 14'h3EFF) begin
                  m_bus = m_buf;
                  m_buf = vram_fetch(a, w.ext);
               end else begin
                  m_buf = vram_fetch(a, w.ext);
                  m_bus = m_buf;
               end
               step_address();
            end
         end
         grp_pkg::OP_WRITE: begin
            m_bus = w.wdata;
            case (w.idx)
               grp_pkg::REG_CTRL: begin
                  m_ctrl = w.wdata;
                  m_t[11:10] = w.wdata[1:0];
               end
               grp_pkg::REG_MASK:  m_mask = w.wdata;
               grp_pkg::REG_SADDR: m_spr_idx = w.wdata;
               grp_pkg::REG_SDATA: begin
                  m_spr[m_spr_idx] = w.wdata;
                  m_spr_idx++;
               end
               grp_pkg::REG_SCROLL: begin
                  if (!m_toggle) begin
                     m_fine_x = w.wdata[2:0];
                     m_t[4:0] = w.wdata[7:3];
                  end else begin
                     m_t[14:12] = w.wdata[2:0];
                     m_t[9:5] = w.wdata[7:3];
                  end
                  m_toggle ^= 1;
               end
               grp_pkg::REG_ADDR: begin
                  if (!m_toggle) m_t = {1'b0, w.wdata[5:0], m_t[7:0]};
                  else begin
                     m_t[7:0] = w.wdata;
                     m_v = m_t;
                  end
                  m_toggle ^= 1;
               end
               grp_pkg::REG_DATA: begin
                  if (a < 14'h2000) begin
                     r.pwrite = 1; r.paddr = a[12:0]; r.pdata = w.wdata;
                  end else if (a <= 14'h3EFF) m_nt[nt_slot(a)] = w.wdata;
                  else m_pal[pal_slot(a)] = w.wdata;
                  step_address();
               end
               default: ;
            endcase
         end
         grp_pkg::OP_FLAGS: m_flags = w.wdata[7:5];
         default: begin
            m_ctrl = 0; m_mask = 0; m_toggle = 0; m_v = 0; m_t = 0;
            m_fine_x = 0; m_bus = 0; m_buf = 0;
         end
      endcase
      r.rdata = m_bus;
      r.vram = m_v[13:0];
      return r;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("timeout at %0t", $time);
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random idling, or a long hold when asked
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
   end

   // response checker
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t unexpected word rdata %h", $time, rsp_read_data);
         end else begin
            e = pending_rsp.pop_front();
            if (e != {rsp_read_data, rsp_pattern_write, rsp_pattern_address,
                      rsp_pattern_write_data, rsp_vram_address}) begin
               errors++;
               $display("%0t expected rd %h pw %b pa %h pd %h va %h,",
                  $time, e.rdata, e.pwrite, e.paddr, e.pdata, e.vram);
               $display("   got rd %h pw %b pa %h pd %h va %h",
                  rsp_read_data, rsp_pattern_write, rsp_pattern_address,
                  rsp_pattern_write_data, rsp_vram_address);
            end
         end
      end
   end

   // offer one word; returns at the edge that takes it, valid still high
   task automatic send_word(bus_word_type w, bit check = 0, rsp_word_type want = '0);
      rsp_word_type p;
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      p = bus_access(w);
      if (check && p != want) begin
         errors++;
         $display("%0t table row expected %h, predictor %h", $time, want, p);
      end
      pending_rsp.push_back(p);
      req_valid <= 1'b1;
      {req_operation, req_register_index, req_write_data, req_pattern_read_data} <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_bus();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      idle_bus();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_mirror(logic [2:0] m);
      drain();
      csr_valid <= 1'b1;
      csr_data <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      m_mirror = m;
   endtask

   // biased random word: mostly data port traffic
   function automatic bus_word_type rand_word();
      bus_word_type w;
      int k;
      w.wdata = 8'($urandom);
      w.ext = 8'($urandom);
      w.idx = 3'($urandom);
      k = $urandom_range(99);
      if (k < 3) w.op = grp_pkg::OP_RESET;
      else if (k < 8) w.op = grp_pkg::OP_FLAGS;
      else if (k < 45) w.op = grp_pkg::OP_READ;
      else w.op = grp_pkg::OP_WRITE;
      if (k >= 8 && $urandom_range(99) < 50) w.idx = grp_pkg::REG_DATA;
      if (w.op == grp_pkg::OP_WRITE && w.idx == grp_pkg::REG_ADDR && $urandom_range(1)) begin
         // steer the high byte toward nametable and palette regions
         w.wdata[5:4] = 2'($urandom_range(2, 3));
      end
      return w;
   endfunction

   row_type      table_rows [$];
   bus_word_type w;
   rsp_word_type z;

   initial begin
      z = '0;
      clear_shadow();
      // directed table: {op, idx, wdata, ext}, check, expected
      table_rows = '{
         '{'{grp_pkg::OP_READ, grp_pkg::REG_STATUS, 8'h00, 8'h00}, 1, '0},
         '{'{grp_pkg::OP_READ, grp_pkg::REG_CTRL, 8'h00, 8'h00}, 1, '0},
         '{'{grp_pkg::OP_FLAGS, grp_pkg::REG_STATUS, 8'hFF, 8'h00}, 1, '0},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_STATUS, 8'hFF, 8'h00}, 1,
           '{8'hFF, 1'b0, 13'h0, 8'h0, 14'h0}},
         '{'{grp_pkg::OP_READ, grp_pkg::REG_STATUS, 8'h00, 8'h00}, 1,
           '{8'hFF, 1'b0, 13'h0, 8'h0, 14'h0}},
         '{'{grp_pkg::OP_READ, grp_pkg::REG_STATUS, 8'h00, 8'h00}, 1,
           '{8'h7F, 1'b0, 13'h0, 8'h0, 14'h0}},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_SADDR, 8'hFF, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_SDATA, 8'hA5, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_SADDR, 8'hFF, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_READ, grp_pkg::REG_SDATA, 8'h00, 8'h00}, 1,
           '{8'hA5, 1'b0, 13'h0, 8'h0, 14'h0}},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_SCROLL, 8'hFF, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_SCROLL, 8'h00, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_ADDR, 8'hFF, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_ADDR, 8'hFF, 8'h00}, 1,
           '{8'hFF, 1'b0, 13'h0, 8'h0, 14'h3FFF}},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_DATA, 8'h3C, 8'h00}, 1,
           '{8'h3C, 1'b0, 13'h0, 8'h0, 14'h0}},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_DATA, 8'hFF, 8'h00}, 1,
           '{8'hFF, 1'b1, 13'h0, 8'hFF, 14'h1}},
         '{'{grp_pkg::OP_READ, grp_pkg::REG_DATA, 8'h00, 8'hC3}, 0, '0},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_CTRL, 8'hFF, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_MASK, 8'hFF, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_ADDR, 8'h3F, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_WRITE, grp_pkg::REG_ADDR, 8'h1F, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_READ, grp_pkg::REG_DATA, 8'h00, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_READ, grp_pkg::REG_DATA, 8'h00, 8'h00}, 0, '0},
         '{'{grp_pkg::OP_RESET, grp_pkg::REG_CTRL, 8'h00, 8'h00}, 1, '0},
         '{'{grp_pkg::OP_READ, grp_pkg::REG_MASK, 8'h00, 8'h00}, 1, '0}
      };
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      set_mirror(grp_pkg::MIR_FOUR);
      foreach (table_rows[i]) send_word(table_rows[i].req, table_rows[i].check,
                                        table_rows[i].rsp);
      // random phases over mirroring modes and idling mixes
      for (int ph = 0; ph < 9; ph++) begin
         set_mirror(ph == 8 ? 3'd7 : 3'(ph % 5));
         if (ph == 3) begin send_idle = 63; recv_idle = 36; end
         if (ph == 6) begin send_idle = 0; recv_idle = 0; end
         if (ph == 4) begin
            // long receiver hold while words keep coming in
            fork
               begin recv_hold = 1; repeat (300) @(negedge clock); recv_hold = 0; end
               begin repeat (40) send_word(rand_word()); idle_bus(); end
            join
         end
         repeat (180) send_word(rand_word());
         // sender pauses until every response is back
         if (ph == 2) drain();
      end
      drain();
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

// File: sim.f
rtl/core/grp_pkg.sv
rtl/core/grp_front.sv
rtl/core/grp_queue.sv
rtl/core/grp_back.sv
rtl/core/graphics_register_port.sv
bench/tb_graphics_register_port.sv
